@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, sampled on aclk, off during reset
`define RTS_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: check failed");

// Condition in one cycle implies consequence in the next
`define RTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/rts_pkg.sv @@
`default_nettype none

package rts_pkg;

    localparam logic [1:0] TOK_OPEN  = 2'd0;
    localparam logic [1:0] TOK_CLOSE = 2'd1;
    localparam logic [1:0] TOK_CTRL  = 2'd2;
    localparam logic [1:0] TOK_TEXT  = 2'd3;

    localparam int unsigned Q_DEPTH = 3;

    typedef struct packed {
        logic [1:0]         token_type;
        logic [7:0]         text_char;
        logic               char_valid;
        logic               token_done;
        logic               has_param;
        logic signed [31:0] param_value;
        logic               last;
    } rts_result_t;

endpackage

`default_nettype wire

@@ rtl/core/rtf_token_scanner_top.sv @@
// Channel  Direction  tdata                          tuser
// s_       in         [7:0] in_byte                  [0] end_of_input
// m_       out        [7:0] text_char,               [1:0] token_type, [2] char_valid,
//                     [39:8] param_value             [3] token_done, [4] has_param
//
// One input byte per cycle while the result queue has room; each transfer gives zero, one or two results.
// Each byte passes the input register, then the result queue (three entries).
// A double result waits in the input register while the queue holds two or more entries.
// aresetn is synchronous, active low; it empties both stages and sets the scanner idle.
// A stall on m_ backs up through the queue to s_tready; no combinational path links them.
`default_nettype none

module rtf_token_scanner_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tuser,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // text_char, param_value
    output logic [4:0]       m_tuser,   // token_type, char_valid, token_done, has_param
    output logic             m_tlast
);

    localparam int unsigned CNT_W = $clog2(rts_pkg::Q_DEPTH + 1);

    logic                 item_valid;
    logic [7:0]           item_byte;
    logic                 item_eoi;
    logic                 take;
    rts_pkg::rts_result_t res0, res1, m_result;
    logic [1:0]           res_n;
    logic [CNT_W-1:0]     space;

    assign take = item_valid && (CNT_W'(res_n) <= space);

    rts_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_eoi   (item_eoi)
    );

    rts_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_byte (item_byte),
        .item_eoi  (item_eoi),
        .take      (take),
        .res0      (res0),
        .res1      (res1),
        .res_n     (res_n)
    );

    rts_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_n   (take ? res_n : 2'd0),
        .push0    (res0),
        .push1    (res1),
        .space    (space),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {m_result.param_value, m_result.text_char};
    assign m_tuser = {m_result.has_param, m_result.token_done, m_result.char_valid,
                      m_result.token_type};
    assign m_tlast = m_result.last;

endmodule

`default_nettype wire

@@ rtl/core/rts_in_stage.sv @@
`default_nettype none

module rts_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       take,
    output logic            item_valid,
    output logic [7:0]      item_byte,
    output logic            item_eoi
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       eoi_reg;
    logic       load;

    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_tdata;
            eoi_reg  <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_eoi   = eoi_reg;

endmodule

`default_nettype wire

@@ rtl/core/rts_scan.sv @@
`default_nettype none

module rts_scan (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [7:0]           item_byte,
    input  wire logic                 item_eoi,
    input  wire logic                 take,
    output rts_pkg::rts_result_t      res0,
    output rts_pkg::rts_result_t      res1,
    output logic [1:0]                res_n
);

    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_BSLASH = 6'b000010,
        MODE_WORD   = 6'b000100,
        MODE_MINUS  = 6'b001000,
        MODE_DIGITS = 6'b010000,
        MODE_TEXT   = 6'b100000
    } mode_t;

    localparam logic [7:0]  CH_LBRACE = 8'h7B;
    localparam logic [7:0]  CH_RBRACE = 8'h7D;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [30:0] MAG_MAX   = 31'h7FFF_FFFF;

    mode_t       mode_reg, mode_next;
    logic        neg_reg, neg_next;
    logic [30:0] mag_reg, mag_next;
    logic        digits_reg, digits_next;

    logic        is_letter, is_digit, is_delim;
    logic [34:0] mag_x10;
    logic [30:0] dig_mag;
    logic [31:0] pv_abs;

    rts_pkg::rts_result_t wd_res, close_res, tdone_res, char_res, cdone_res;
    rts_pkg::rts_result_t idle_res;
    logic                 idle_emit;
    mode_t                idle_mode;
    rts_pkg::rts_result_t res [2];
    logic [1:0]           n;

    assign is_letter = (item_byte >= 8'h61 && item_byte <= 8'h7A) ||
                       (item_byte >= 8'h41 && item_byte <= 8'h5A);
    assign is_digit  = item_byte >= 8'h30 && item_byte <= 8'h39;
    assign is_delim  = item_byte == CH_BSLASH || item_byte == CH_LBRACE ||
                       item_byte == CH_RBRACE || item_byte == CH_LF ||
                       item_byte == CH_CR;

    // magnitude * 10 + digit, saturating
    assign mag_x10 = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                   + {31'd0, item_byte[3:0]};
    assign dig_mag = (mag_x10 > {4'd0, MAG_MAX}) ? MAG_MAX : mag_x10[30:0];
    assign pv_abs  = {1'b0, mag_reg};

    always_comb begin
        wd_res             = '0;
        wd_res.token_type  = rts_pkg::TOK_CTRL;
        wd_res.token_done  = 1'b1;
        wd_res.has_param   = digits_reg;
        if (digits_reg) begin
            wd_res.param_value = neg_reg ? -pv_abs : pv_abs;
        end

        close_res            = '0;
        close_res.token_type = rts_pkg::TOK_CLOSE;
        close_res.token_done = 1'b1;

        tdone_res            = '0;
        tdone_res.token_type = rts_pkg::TOK_TEXT;
        tdone_res.token_done = 1'b1;

        cdone_res            = '0;
        cdone_res.token_type = rts_pkg::TOK_CTRL;
        cdone_res.token_done = 1'b1;

        char_res            = '0;
        char_res.token_type = rts_pkg::TOK_CTRL;
        char_res.text_char  = item_byte;
        char_res.char_valid = 1'b1;

        // byte seen between tokens
        idle_res  = '0;
        idle_emit = 1'b1;
        idle_mode = MODE_IDLE;
        if (item_byte == CH_LF || item_byte == CH_CR) begin
            idle_emit = 1'b0;
        end else if (item_byte == CH_LBRACE) begin
            idle_res.token_type = rts_pkg::TOK_OPEN;
            idle_res.token_done = 1'b1;
        end else if (item_byte == CH_RBRACE) begin
            idle_res.token_type = rts_pkg::TOK_CLOSE;
            idle_res.token_done = 1'b1;
        end else if (item_byte == CH_BSLASH) begin
            idle_emit = 1'b0;
            idle_mode = MODE_BSLASH;
        end else begin
            idle_res.token_type = rts_pkg::TOK_TEXT;
            idle_res.text_char  = item_byte;
            idle_res.char_valid = 1'b1;
            idle_mode           = MODE_TEXT;
        end
    end

    always_comb begin
        res[0]      = '0;
        res[1]      = '0;
        n           = 2'd0;
        mode_next   = mode_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        digits_next = digits_reg;

        if (item_eoi) begin
            if (mode_reg == MODE_WORD || mode_reg == MODE_DIGITS) begin
                res[0] = wd_res;
                n      = 2'd1;
            end else if (mode_reg == MODE_TEXT) begin
                res[0] = tdone_res;
                n      = 2'd1;
            end
            res[n[0]]   = close_res;
            n           = n + 2'd1;
            mode_next   = MODE_IDLE;
            neg_next    = 1'b0;
            mag_next    = '0;
            digits_next = 1'b0;
        end else begin
            unique case (mode_reg)
                MODE_BSLASH: begin
                    res[0] = char_res;
                    n      = 2'd1;
                    if (is_letter) begin
                        mode_next = MODE_WORD;
                    end else begin
                        res[1]    = cdone_res;
                        n         = 2'd2;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_WORD, MODE_MINUS, MODE_DIGITS: begin
                    if (mode_reg == MODE_WORD && is_letter) begin
                        res[0] = char_res;
                        n      = 2'd1;
                    end else if (mode_reg == MODE_WORD && item_byte == CH_MINUS) begin
                        neg_next  = 1'b1;
                        mode_next = MODE_MINUS;
                    end else if (is_digit) begin
                        mag_next    = dig_mag;
                        digits_next = 1'b1;
                        mode_next   = MODE_DIGITS;
                    end else begin
                        res[0]      = wd_res;
                        n           = 2'd1;
                        neg_next    = 1'b0;
                        mag_next    = '0;
                        digits_next = 1'b0;
                        mode_next   = MODE_IDLE;
                        if (item_byte != CH_SPACE) begin
                            mode_next = idle_mode;
                            if (idle_emit) begin
                                res[1] = idle_res;
                                n      = 2'd2;
                            end
                        end
                    end
                end
                MODE_TEXT: begin
                    if (is_delim) begin
                        res[0]    = tdone_res;
                        n         = 2'd1;
                        mode_next = idle_mode;
                        if (idle_emit) begin
                            res[1] = idle_res;
                            n      = 2'd2;
                        end
                    end else begin
                        res[0]            = idle_res;
                        res[0].text_char  = item_byte;
                        res[0].char_valid = 1'b1;
                        res[0].token_type = rts_pkg::TOK_TEXT;
                        res[0].token_done = 1'b0;
                        n                 = 2'd1;
                    end
                end
                default: begin
                    mode_next = idle_mode;
                    if (idle_emit) begin
                        res[0] = idle_res;
                        n      = 2'd1;
                    end
                end
            endcase
        end

        if (n == 2'd1) begin
            res[0].last = 1'b1;
        end else if (n == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            digits_reg <= 1'b0;
        end else if (take) begin
            mode_reg   <= mode_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
            digits_reg <= digits_next;
        end
    end

    assign res0  = res[0];
    assign res1  = res[1];
    assign res_n = n;

    `RTS_ASSERT(a_char_not_done, !(res0.char_valid && res0.token_done))
    `RTS_ASSERT(a_param_on_ctrl_done,
        !res0.has_param || (res0.token_done && res0.token_type == rts_pkg::TOK_CTRL))

endmodule

`default_nettype wire

@@ rtl/core/rts_out_queue.sv @@
`default_nettype none

module rts_out_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [1:0]           push_n,
    input  wire rts_pkg::rts_result_t push0,
    input  wire rts_pkg::rts_result_t push1,
    output logic [$clog2(rts_pkg::Q_DEPTH+1)-1:0] space,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rts_pkg::rts_result_t      m_result
);

    `include "assert_macros.svh"

    localparam int unsigned DEPTH = rts_pkg::Q_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rts_pkg::rts_result_t mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign pop        = m_valid && m_ready;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push_n == 2'd1) begin
            wr_ptr_next = wr_ptr_inc;
        end else if (push_n == 2'd2) begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = CNT_W'(({1'b0, count_reg} + (CNT_W + 1)'(push_n))
                             - (CNT_W + 1)'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[wr_ptr_inc] <= push1;
        end
    end

    assign space    = CNT_W'(DEPTH) - count_reg;
    assign m_valid  = count_reg != '0;
    assign m_result = mem[rd_ptr_reg];

    `RTS_ASSERT(a_no_overflow, CNT_W'(push_n) <= space)
    `RTS_ASSERT_NEXT(a_pop_drains, pop && push_n == 2'd0,
        count_reg == $past(count_reg) - CNT_W'(1))

endmodule

`default_nettype wire
